// ----- rtl/pscl_pkg.sv -----
// shared types and codes for the per-source connection limiter
// no dependencies; imported by the cell, controller and top level

package pscl_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_COUNTED  = 3'd0,
        ST_LIMIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    // normalized peer address key
    typedef struct packed {
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } key_t;

    // token handed from cell to cell
    typedef struct packed {
        logic        active;     // token present in this slot
        logic        is_release; // item is a release
        logic        claim;      // second pass: first free cell takes the key
        logic        found;      // a cell matched (search) or took the key (claim)
        logic        free_seen;  // some cell was free during the search
        logic        refused;    // matching cell was at or above the limit
        logic [15:0] count;      // count reported by the matching cell
    } tok_t;

endpackage

// ----- rtl/per_source_connection_limiter_unit.sv -----
// per-source connection limiter: controller plus a chain of table cells
// depends on pscl_pkg, pscl_cell and pscl_ctrl
//
// Usage:
// - input channel (in_valid/in_stall) carries one request item: open or
//   release, with a peer address; output channel (out_valid/out_stall)
//   returns one result item per request: allowed, status, count_after.
// - the table is a chain of TABLE_ENTRIES cells; the item token steps one
//   cell per cycle, so one item is worked on at a time.
// - an unknown address goes straight to the result; a listed address, a
//   release or a refusal takes one search pass through the chain, and a
//   new address a second, claim pass to the first free cell.
// - a new item is accepted the cycle after the previous result is loaded
//   into the output register, even while that result is still stalled.
// - a stalled result holds in the output register; the block waits with
//   its next result until the output register is taken.
// - reset clears all entries and sets max_per_address to 10; the limit is
//   written through cfg_wr_en/cfg_wr_data; the user must do so only while
//   no item is in flight, as the block itself does not enforce it.

module per_source_connection_limiter_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic        address_known,
    input  logic        address_family,
    input  logic [63:0] address_high,
    input  logic [63:0] address_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        allowed,
    output logic [2:0]  status,
    output logic [15:0] count_after
);
    import pscl_pkg::*;

    logic [15:0] max_reg;
    key_t        key;
    tok_t        chain [TABLE_ENTRIES+1];

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 16'd10;
        end
        else if (cfg_wr_en)
        begin
            max_reg <= cfg_wr_data;
        end
    end

    // item sequencer
    pscl_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .address_known   (address_known),
        .address_family  (address_family),
        .address_high    (address_high),
        .address_low     (address_low),
        .max_per_address (max_reg),
        .key             (key),
        .launch          (chain[0]),
        .chain_out       (chain[TABLE_ENTRIES]),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .allowed         (allowed),
        .status          (status),
        .count_after     (count_after)
    );

    // chain of table cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        pscl_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .key             (key),
            .max_per_address (max_reg),
            .tok_in          (chain[i]),
            .tok_out         (chain[i+1])
        );
    end

endmodule

// ----- rtl/pscl_cell.sv -----
// one table entry of the limiter chain: key, count and valid bit
// depends on pscl_pkg (key_t, tok_t)

module pscl_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  pscl_pkg::key_t key,
    input  logic [15:0]    max_per_address,
    input  pscl_pkg::tok_t tok_in,
    output pscl_pkg::tok_t tok_out
);
    import pscl_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    key_t        key_reg;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        key_we;
    logic        match;
    logic [15:0] dec_count;
    tok_t        tok_reg;
    tok_t        tok_next;

    assign match     = valid_reg && (key_reg == key);
    assign dec_count = (count_reg == 16'd0) ? 16'd0 : count_reg - 16'd1;

    // search or claim step on the passing item token
    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        count_next = count_reg;
        key_we     = 1'b0;
        if (tok_in.active && !tok_in.claim)
        begin
            tok_next.free_seen = tok_in.free_seen | ~valid_reg;
            if (match)
            begin
                tok_next.found = 1'b1;
                if (tok_in.is_release)
                begin
                    tok_next.count = dec_count;
                    count_next     = dec_count;
                    if (dec_count == 16'd0)
                    begin
                        valid_next = 1'b0;
                    end
                end
                else if (count_reg >= max_per_address)
                begin
                    tok_next.refused = 1'b1;
                    tok_next.count   = count_reg;
                end
                else
                begin
                    tok_next.count = count_reg + 16'd1;
                    count_next     = count_reg + 16'd1;
                end
            end
        end
        else if (tok_in.active && tok_in.claim && !tok_in.found && !valid_reg)
        begin
            tok_next.found = 1'b1;
            tok_next.count = 16'd1;
            valid_next     = 1'b1;
            count_next     = 16'd1;
            key_we         = 1'b1;
        end
    end

    // valid bit and token slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        if (key_we)
        begin
            key_reg <= key;
        end
    end

    assign tok_out = tok_reg;

    // a claim is taken only by a free cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.active && tok_in.claim && !tok_in.found && !valid_reg) |=> valid_reg)
        else $error("free cell did not take the claimed key");

    // a matched release of a last connection frees the entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.active && !tok_in.claim && tok_in.is_release && match && count_reg <= 16'd1)
        |=> !valid_reg)
        else $error("entry not freed at zero count");

    // a new entry starts with a count of one
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> count_reg == 16'd1)
        else $error("new entry count is not one");

endmodule

// ----- rtl/pscl_ctrl.sv -----
// item sequencer: launches search and claim passes, builds the result item
// depends on pscl_pkg (key_t, tok_t, status_t)

module pscl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           req_type,
    input  logic           address_known,
    input  logic           address_family,
    input  logic [63:0]    address_high,
    input  logic [63:0]    address_low,
    input  logic [15:0]    max_per_address,
    output pscl_pkg::key_t key,
    output pscl_pkg::tok_t launch,
    input  pscl_pkg::tok_t chain_out,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           allowed,
    output logic [2:0]     status,
    output logic [15:0]    count_after
);
    import pscl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_CLAIM  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    tok_t        launch_reg;
    tok_t        launch_next;
    key_t        key_reg;
    logic        rel_reg;
    logic        res_allowed_reg;
    logic        res_allowed_next;
    status_t     res_status_reg;
    status_t     res_status_next;
    logic [15:0] res_count_reg;
    logic [15:0] res_count_next;
    logic        out_valid_reg;
    logic        allowed_reg;
    status_t     status_reg;
    logic [15:0] count_reg;
    logic        in_take;
    logic        out_load;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // sequencing of one item
    always_comb
    begin
        state_next       = state_reg;
        launch_next      = '0;
        res_allowed_next = res_allowed_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (!address_known)
                    begin
                        res_allowed_next = 1'b1;
                        res_status_next  = ST_UNKNOWN;
                        res_count_next   = 16'd0;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        launch_next.active     = 1'b1;
                        launch_next.is_release = req_type;
                        state_next             = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (chain_out.active)
                begin
                    state_next = S_FINISH;
                    priority if (chain_out.found && rel_reg)
                    begin
                        res_allowed_next = 1'b1;
                        res_status_next  = ST_RELEASED;
                        res_count_next   = chain_out.count;
                    end
                    else if (chain_out.found && chain_out.refused)
                    begin
                        res_allowed_next = 1'b0;
                        res_status_next  = ST_LIMIT;
                        res_count_next   = chain_out.count;
                    end
                    else if (chain_out.found)
                    begin
                        res_allowed_next = 1'b1;
                        res_status_next  = ST_COUNTED;
                        res_count_next   = chain_out.count;
                    end
                    else if (rel_reg)
                    begin
                        res_allowed_next = 1'b1;
                        res_status_next  = ST_NOTFOUND;
                        res_count_next   = 16'd0;
                    end
                    else if (max_per_address == 16'd0)
                    begin
                        res_allowed_next = 1'b0;
                        res_status_next  = ST_LIMIT;
                        res_count_next   = 16'd0;
                    end
                    else if (!chain_out.free_seen)
                    begin
                        res_allowed_next = 1'b0;
                        res_status_next  = ST_FULL;
                        res_count_next   = 16'd0;
                    end
                    else
                    begin
                        launch_next.active = 1'b1;
                        launch_next.claim  = 1'b1;
                        state_next         = S_CLAIM;
                    end
                end
            end
            S_CLAIM:
            begin
                if (chain_out.active)
                begin
                    res_allowed_next = 1'b1;
                    res_status_next  = ST_COUNTED;
                    res_count_next   = 16'd1;
                    state_next       = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item key, kept for the whole item; ipv4 keys use the low 32 bits only
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rel_reg        <= req_type;
            key_reg.family <= address_family;
            if (address_family)
            begin
                key_reg.addr_high <= address_high;
                key_reg.addr_low  <= address_low;
            end
            else
            begin
                key_reg.addr_high <= 64'd0;
                key_reg.addr_low  <= {32'd0, address_low[31:0]};
            end
        end
        res_allowed_reg <= res_allowed_next;
        res_status_reg  <= res_status_next;
        res_count_reg   <= res_count_next;
        if (out_load)
        begin
            allowed_reg <= res_allowed_reg;
            status_reg  <= res_status_reg;
            count_reg   <= res_count_reg;
        end
    end

    assign key         = key_reg;
    assign launch      = launch_reg;
    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign status      = status_reg;
    assign count_after = count_reg;

    // a token leaves the chain only while a pass is running
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active |-> (state_reg == S_SEARCH || state_reg == S_CLAIM))
        else $error("token left the chain outside a pass");

    // a claim pass always finds the free entry seen by the search
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM && chain_out.active) |-> chain_out.found)
        else $error("claim pass found no free entry");

    // refusals carry only the limit or table full codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !allowed_reg) |-> (status_reg == ST_LIMIT || status_reg == ST_FULL))
        else $error("refused item with a non-refusal status");

endmodule
